@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bf3_pkg.sv @@
// shared constants, types and helpers for the 3x3 box filter
`timescale 1ns / 1ps

package bf3_pkg;

    localparam int VALUE_W = 32;
    localparam int SUM_W   = 36;
    localparam int DIM_W   = 11;

    localparam logic [DIM_W-1:0] MAX_WIDTH  = 11'd1024;
    localparam logic [DIM_W-1:0] MAX_HEIGHT = 11'd1024;
    localparam logic [DIM_W-1:0] MIN_DIM    = 11'd3;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified window, handed from front to back
    typedef struct packed {
        logic                       live;
        logic                       border;
        logic                       fend;
        logic signed [VALUE_W-1:0]  border_value;
        logic signed [SUM_W-1:0]    sum;
    } bf3_item_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < MIN_DIM)
        begin
            r = MIN_DIM;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/bf3_queue.sv @@
// small fifo between the window front end and the divide back end
`timescale 1ns / 1ps

module bf3_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  bf3_pkg::bf3_item_t        push_item,
    input  logic                      pop,
    output bf3_pkg::bf3_item_t        head,
    output logic                      empty,
    output logic [bf3_pkg::QCNT_W-1:0] count
);
    import bf3_pkg::*;

    bf3_item_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

@@ hw/rtl/bf3_front.sv @@
// front end: position counters, line stores, window column sums
`timescale 1ns / 1ps

module bf3_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bf3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bf3_pkg::DIM_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [bf3_pkg::VALUE_W-1:0] sample_value,
    input  logic [bf3_pkg::QCNT_W-1:0]      queue_count,
    output logic                            push,
    output bf3_pkg::bf3_item_t              push_item
);
    import bf3_pkg::*;

    // line stores
    logic [VALUE_W-1:0] upper_mem  [1 << COL_W];
    logic [VALUE_W-1:0] middle_mem [1 << COL_W];

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [DIM_W-1:0] primed_reg, primed_next;
    logic [DIM_W-1:0] fill_reg, fill_next;

    logic             accept, restart, primed, interior, fend;
    logic [DIM_W-1:0] in_col_ext, out_col_ext, out_row_ext;
    logic [QCNT_W-1:0] in_flight;

    // stage b
    logic                      b_valid_reg, b_ok_reg, b_live_reg, b_border_reg, b_fend_reg;
    logic [COL_W-1:0]          b_ic_reg;
    logic signed [VALUE_W-1:0] b_x_reg;
    logic signed [VALUE_W-1:0] rd_upper_reg, rd_middle_reg;
    logic signed [VALUE_W-1:0] cu, cm;
    logic signed [VALUE_W+1:0] ncol;
    logic signed [VALUE_W+2:0] pair;
    logic signed [VALUE_W+1:0] s0_reg, s1_reg;
    logic signed [VALUE_W-1:0] mid_reg;

    // stage c
    logic                      c_valid_reg, c_live_reg, c_border_reg, c_fend_reg;
    logic signed [VALUE_W+2:0] c_pair_reg;
    logic signed [VALUE_W+1:0] c_ncol_reg;
    logic signed [VALUE_W-1:0] c_bval_reg;

    assign in_flight = QCNT_W'(b_valid_reg) + QCNT_W'(c_valid_reg);
    assign in_ready  = (queue_count + in_flight) < QCNT_W'(QUEUE_DEPTH);
    assign accept    = in_valid && in_ready;
    assign restart   = cfg_we && (cfg_index == REG_FRAME_WIDTH ||
                                  cfg_index == REG_FRAME_HEIGHT);

    assign in_col_ext  = DIM_W'(in_col_reg);
    assign out_col_ext = DIM_W'(out_col_reg);
    assign out_row_ext = DIM_W'(out_row_reg);

    assign primed   = primed_reg >= (width_reg + DIM_W'(1));
    assign interior = (out_row_reg != '0) && ((out_row_ext + DIM_W'(2)) <= height_reg) &&
                      (out_col_reg != '0) && ((out_col_ext + DIM_W'(2)) <= width_reg);
    assign fend     = ((out_row_ext + DIM_W'(1)) == height_reg) &&
                      ((out_col_ext + DIM_W'(1)) == width_reg);

    always_comb
    begin
        in_col_next  = in_col_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        primed_next  = primed_reg;
        fill_next    = fill_reg;
        if (restart)
        begin
            in_col_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            primed_next  = '0;
        end
        else if (accept)
        begin
            if (primed)
            begin
                if ((out_col_ext + DIM_W'(1)) >= width_reg)
                begin
                    out_col_next = '0;
                    if ((out_row_ext + DIM_W'(1)) >= height_reg)
                    begin
                        out_row_next = '0;
                    end
                    else
                    begin
                        out_row_next = out_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
            else
            begin
                primed_next = primed_reg + DIM_W'(1);
            end
            if ((in_col_ext + DIM_W'(1)) >= width_reg)
            begin
                in_col_next = '0;
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            // stores are written in column order from zero, so a count marks the written part
            if (in_col_ext == fill_reg)
            begin
                fill_next = fill_reg + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= MAX_WIDTH;
            height_reg  <= MAX_HEIGHT;
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            primed_reg  <= '0;
            fill_reg    <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            s0_reg      <= '0;
            s1_reg      <= '0;
            mid_reg     <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_FRAME_WIDTH)
            begin
                width_reg <= clamp_dim(cfg_data, MAX_WIDTH);
            end
            if (cfg_we && cfg_index == REG_FRAME_HEIGHT)
            begin
                height_reg <= clamp_dim(cfg_data, MAX_HEIGHT);
            end
            in_col_reg  <= in_col_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            primed_reg  <= primed_next;
            fill_reg    <= fill_next;
            b_valid_reg <= accept;
            c_valid_reg <= b_valid_reg;
            if (b_valid_reg)
            begin
                s0_reg  <= s1_reg;
                s1_reg  <= ncol;
                mid_reg <= cm;
            end
        end
    end

    // stage a: issue store reads, snapshot output position; stage b writes the stores back
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_upper_reg  <= upper_mem[in_col_reg];
            rd_middle_reg <= middle_mem[in_col_reg];
            b_ic_reg      <= in_col_reg;
            b_x_reg       <= sample_value;
            b_ok_reg      <= in_col_ext < fill_reg;
            b_live_reg    <= primed;
            b_border_reg  <= !interior;
            b_fend_reg    <= fend;
        end
        if (b_valid_reg)
        begin
            upper_mem[b_ic_reg]  <= cm;
            middle_mem[b_ic_reg] <= b_x_reg;
        end
    end

    // stage b: new column sum and sum of the two older columns
    assign cu   = b_ok_reg ? rd_upper_reg : '0;
    assign cm   = b_ok_reg ? rd_middle_reg : '0;
    assign ncol = (VALUE_W+2)'(cu) + (VALUE_W+2)'(cm) + (VALUE_W+2)'(b_x_reg);
    assign pair = (VALUE_W+3)'(s0_reg) + (VALUE_W+3)'(s1_reg);

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            c_pair_reg   <= pair;
            c_ncol_reg   <= ncol;
            c_bval_reg   <= mid_reg;
            c_live_reg   <= b_live_reg;
            c_border_reg <= b_border_reg;
            c_fend_reg   <= b_fend_reg;
        end
    end

    // stage c: full nine-point sum into the queue
    assign push                   = c_valid_reg;
    assign push_item.live         = c_live_reg;
    assign push_item.border       = c_border_reg;
    assign push_item.fend         = c_fend_reg;
    assign push_item.border_value = c_bval_reg;
    assign push_item.sum          = SUM_W'(c_pair_reg) + SUM_W'(c_ncol_reg);

endmodule

@@ hw/rtl/bf3_back.sv @@
// back end: rounded divide by nine and output register
`timescale 1ns / 1ps

module bf3_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               queue_empty,
    input  bf3_pkg::bf3_item_t                 head,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [bf3_pkg::VALUE_W-1:0] result_value,
    output logic                               result_valid,
    output logic                               frame_end
);
    import bf3_pkg::*;

    localparam int N_W    = SUM_W - 1;
    localparam int STAGES = 7;

    typedef struct packed {
        logic                      live;
        logic                      border;
        logic                      fend;
        logic                      neg;
        logic signed [VALUE_W-1:0] border_value;
        logic [5:0]                n_low;
    } bf3_tag_t;

    logic [STAGES-1:0]  vld_reg;
    bf3_tag_t           tag_reg [STAGES-1];
    bf3_tag_t           tag_in;
    logic               enable;

    logic [SUM_W-1:0]   inv_sum;
    logic [N_W-1:0]     n_in;
    logic [N_W-1:0]     n_reg, t1_reg, t2_reg, t3_reg;
    logic [N_W-1:0]     t4;
    logic [VALUE_W-1:0] q0_reg, q_reg;
    logic [5:0]         nine_q, rem;
    logic [1:0]         delta;

    logic signed [VALUE_W-1:0] result_value_reg;
    logic                      result_valid_reg, frame_end_reg;

    assign enable = !vld_reg[STAGES-1] || out_ready;
    assign pop    = enable && !queue_empty;

    // magnitude plus half of nine, sign folded into one add
    assign inv_sum = ~head.sum;
    assign n_in    = head.sum[SUM_W-1] ? (inv_sum[N_W-1:0] + N_W'(5))
                                       : (head.sum[N_W-1:0] + N_W'(4));

    always_comb
    begin
        tag_in.live         = head.live;
        tag_in.border       = head.border;
        tag_in.fend         = head.fend;
        tag_in.neg          = head.sum[SUM_W-1];
        tag_in.border_value = head.border_value;
        tag_in.n_low        = n_in[5:0];
    end

    // 1/9 = 7/64 * (1 + 2^-6 + 2^-12 + ...), one term per stage
    assign t4 = t3_reg + (t3_reg >> 24);

    // estimate is exact or up to two low, remainder fits in six bits
    assign nine_q = {q0_reg[2:0], 3'b000} + q0_reg[5:0];
    assign rem    = tag_reg[4].n_low - nine_q;
    assign delta  = (rem >= 6'd18) ? 2'd2 : ((rem >= 6'd9) ? 2'd1 : 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (enable)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < STAGES - 1; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
            n_reg  <= n_in;
            t1_reg <= n_reg - (n_reg >> 3);
            t2_reg <= t1_reg + (t1_reg >> 6);
            t3_reg <= t2_reg + (t2_reg >> 12);
            q0_reg <= t4[N_W-1:3];
            q_reg  <= q0_reg + VALUE_W'(delta);
            result_valid_reg <= tag_reg[5].live;
            frame_end_reg    <= tag_reg[5].fend;
            if (!tag_reg[5].live)
            begin
                result_value_reg <= '0;
            end
            else if (tag_reg[5].border)
            begin
                result_value_reg <= tag_reg[5].border_value;
            end
            else if (tag_reg[5].neg)
            begin
                result_value_reg <= VALUE_W'(0) - q_reg;
            end
            else
            begin
                result_value_reg <= q_reg;
            end
        end
    end

    assign out_valid    = vld_reg[STAGES-1];
    assign result_value = result_value_reg;
    assign result_valid = result_valid_reg;
    assign frame_end    = frame_end_reg;

endmodule

@@ hw/rtl/box_filter_3x3_stencil.sv @@
// top level of the streaming 3x3 box filter
//
//  channel  dir  handshake             payload
//  input    in   in_valid / in_ready   sample_value
//  output   out  out_valid / out_ready result_value, result_valid, frame_end
//  config   in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// one beat per cycle sustained in each direction while out_ready stays high; each input beat yields one output beat
// the path from input to output beat runs through 3 front stages, the queue and 7 divide stages
// line stores need no clearing pass; a fill count masks entries not yet written after reset
// an 8-entry queue decouples the two ends; in_ready drops when queued and in-flight front items fill it
// cfg_ready is always high; a write to either size register restarts the frame position
`timescale 1ns / 1ps

module box_filter_3x3_stencil (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bf3_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bf3_pkg::DIM_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [bf3_pkg::VALUE_W-1:0] sample_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [bf3_pkg::VALUE_W-1:0] result_value,
    output logic                               result_valid,
    output logic                               frame_end
);
    import bf3_pkg::*;

    logic              cfg_we;
    logic              push, pop, queue_empty;
    bf3_item_t         push_item, head;
    logic [QCNT_W-1:0] queue_count;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    bf3_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_value (sample_value),
        .queue_count  (queue_count),
        .push         (push),
        .push_item    (push_item)
    );

    bf3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty),
        .count     (queue_count)
    );

    bf3_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .result_valid (result_valid),
        .frame_end    (frame_end)
    );

endmodule

@@ hw/rtl/bf3_checker.sv @@
// port-level checks for the 3x3 box filter, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bf3_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [bf3_pkg::VALUE_W-1:0] result_value,
    input logic                               result_valid,
    input logic                               frame_end
);
    import bf3_pkg::*;

    `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(result_valid) && $stable(frame_end), "stalled output beat changed")
    `ASSERT_IMP(a_fend_live, out_valid && frame_end, result_valid, "frame end on a priming beat")
    `ASSERT_IMP(a_prime_zero, out_valid && !result_valid, result_value == '0, "priming beat not zero")

endmodule

bind box_filter_3x3_stencil bf3_checker u_bf3_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .result_valid (result_valid),
    .frame_end    (frame_end)
);
